[design/jkse_pkg.sv]
// ----------------------------------------------------------------------------
// jkse_pkg
// Shared types and constants of the JSON key string extractor.
// ----------------------------------------------------------------------------
package jkse_pkg;

	localparam int unsigned MAX_KEY_LEN_DEF = 8;
	localparam int unsigned KEY_W           = 64;
	localparam int unsigned KLEN_W          = 4;
	localparam int unsigned CNT_W           = 4;
	localparam int unsigned QUEUE_DEPTH     = 4;
	localparam int unsigned ADDR_W          = 4;
	localparam int unsigned PDATA_W         = 64;

	localparam logic [ADDR_W-1:0] ADDR_KEY_CHARS  = 4'd0;
	localparam logic [ADDR_W-1:0] ADDR_KEY_LENGTH = 4'd8;

	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef struct packed {
		logic       has_data;
		logic [7:0] data_byte;
		logic       has_final;
		logic       found;
	} jkse_entry_t;

	function automatic logic [7:0] decode_escape(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CH_N:    r = CH_LF;
			CH_R:    r = CH_CR;
			CH_T:    r = CH_TAB;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

[design/jkse_if.sv]
// ----------------------------------------------------------------------------
// jkse_in_if / jkse_out_if
// Valid/ready channels for message bytes and extracted results.
// ----------------------------------------------------------------------------
interface jkse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       message_end;

	modport source (output valid, output in_byte, output message_end, input ready);
	modport sink   (input valid, input in_byte, input message_end, output ready);
endinterface

interface jkse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic       is_final;
	logic       found;

	modport source (output valid, output value_byte, output is_final, output found,
		input ready);
	modport sink   (input valid, input value_byte, input is_final, input found,
		output ready);
endinterface

[design/jkse_front.sv]
// ----------------------------------------------------------------------------
// jkse_front
// Byte window, key match and phase tracking; one queue entry per beat that
// yields results.
// ----------------------------------------------------------------------------
module jkse_front #(
	parameter int unsigned MAX_KEY_LEN = jkse_pkg::MAX_KEY_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       in_byte,
	input  logic                             message_end,
	input  logic [jkse_pkg::KEY_W-1:0]       key_chars,
	input  logic [jkse_pkg::KLEN_W-1:0]      key_length,
	input  logic                             q_full,
	output logic                             q_push,
	output jkse_pkg::jkse_entry_t            q_entry
);

	localparam int unsigned WIN = MAX_KEY_LEN + 2;
	localparam logic [jkse_pkg::CNT_W-1:0] WIN_C = jkse_pkg::CNT_W'(WIN);

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_COLON  = 3'd1,
		PH_OPEN   = 3'd2,
		PH_STRING = 3'd3,
		PH_ESCAPE = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [7:0]                 win_q [WIN];
	logic [7:0]                 new_win [WIN];
	logic [jkse_pkg::CNT_W-1:0] cnt_q, cnt_new;
	logic [jkse_pkg::KLEN_W-1:0] eff_len, plen;
	logic [WIN-1:0]             pos_ok;
	logic                       match;
	logic                       fire;
	logic                       verdict;
	jkse_pkg::jkse_entry_t      ent;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;

	assign eff_len = (key_length > jkse_pkg::KLEN_W'(MAX_KEY_LEN)) ?
		jkse_pkg::KLEN_W'(MAX_KEY_LEN) : key_length;
	assign plen    = eff_len + jkse_pkg::KLEN_W'(2);
	assign cnt_new = (cnt_q < WIN_C) ? cnt_q + 1'b1 : cnt_q;

	assign new_win[0] = in_byte;
	for (genvar j = 1; j < WIN; j++) begin : g_shift
		assign new_win[j] = win_q[j-1];
	end

	for (genvar j = 0; j < WIN; j++) begin : g_cmp
		localparam logic [jkse_pkg::KLEN_W-1:0] JV = jkse_pkg::KLEN_W'(j);
		logic [jkse_pkg::KLEN_W-1:0] kidx;
		logic [7:0]                  want;
		assign kidx = eff_len - JV;
		assign want = (JV == '0 || JV == plen - 1'b1) ? jkse_pkg::CH_QUOTE :
			key_chars[8*kidx[2:0] +: 8];
		assign pos_ok[j] = (JV >= plen) || (new_win[j] == want);
	end

	assign match = (&pos_ok) && (cnt_new >= plen);

	always_comb begin
		phase_d = phase_q;
		verdict = 1'b0;
		ent     = '0;
		case (phase_q)
			PH_SEARCH: begin
				if (match) phase_d = PH_COLON;
			end
			PH_COLON: begin
				if (in_byte == jkse_pkg::CH_COLON) phase_d = PH_OPEN;
			end
			PH_OPEN: begin
				if (in_byte == jkse_pkg::CH_QUOTE) phase_d = PH_STRING;
			end
			PH_STRING: begin
				if (in_byte == jkse_pkg::CH_BSLASH) begin
					phase_d = PH_ESCAPE;
				end else if (in_byte == jkse_pkg::CH_QUOTE) begin
					ent.has_final = 1'b1;
					ent.found     = 1'b1;
					verdict       = 1'b1;
					phase_d       = PH_DONE;
				end else begin
					ent.has_data  = 1'b1;
					ent.data_byte = in_byte;
				end
			end
			PH_ESCAPE: begin
				ent.has_data  = 1'b1;
				ent.data_byte = jkse_pkg::decode_escape(in_byte);
				phase_d       = PH_STRING;
			end
			default: begin
				verdict = 1'b1;
			end
		endcase
		if (message_end && !verdict) begin
			ent.has_final = 1'b1;
			ent.found     = 1'b0;
		end
	end

	assign q_push  = fire && (ent.has_data || ent.has_final);
	assign q_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			cnt_q   <= '0;
			for (int i = 0; i < WIN; i++) win_q[i] <= '0;
		end else if (fire) begin
			if (message_end) begin
				phase_q <= PH_SEARCH;
				cnt_q   <= '0;
				for (int i = 0; i < WIN; i++) win_q[i] <= '0;
			end else begin
				phase_q <= phase_d;
				cnt_q   <= cnt_new;
				for (int i = 0; i < WIN; i++) win_q[i] <= new_win[i];
			end
		end
	end

endmodule

[design/jkse_queue.sv]
// ----------------------------------------------------------------------------
// jkse_queue
// Short FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module jkse_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  jkse_pkg::jkse_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  not_empty,
	output jkse_pkg::jkse_entry_t head
);

	localparam int unsigned DEPTH = jkse_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	jkse_pkg::jkse_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_q, rd_q;
	logic [CNT_W-1:0]      cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/jkse_back.sv]
// ----------------------------------------------------------------------------
// jkse_back
// Holds one entry and sends its data beat, then its verdict beat, whichever it has.
// ----------------------------------------------------------------------------
module jkse_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  jkse_pkg::jkse_entry_t q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            value_byte,
	output logic                  is_final,
	output logic                  found
);

	jkse_pkg::jkse_entry_t cur_q;
	logic                  busy;
	logic                  fire;
	logic                  last_beat;

	assign busy      = cur_q.has_data || cur_q.has_final;
	assign out_valid = busy;
	assign fire      = out_valid && out_ready;
	assign last_beat = !(cur_q.has_data && cur_q.has_final);
	assign q_pop     = q_not_empty && (!busy || (fire && last_beat));

	assign value_byte = cur_q.has_data ? cur_q.data_byte : 8'h00;
	assign is_final   = !cur_q.has_data;
	assign found      = !cur_q.has_data && cur_q.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (q_pop) begin
			cur_q <= q_head;
		end else if (fire) begin
			if (cur_q.has_data) begin
				cur_q.has_data <= 1'b0;
			end else begin
				cur_q.has_final <= 1'b0;
			end
		end
	end

endmodule

[design/json_key_string_extractor_top.sv]
// ----------------------------------------------------------------------------
// json_key_string_extractor_top
// A byte's result entry is pushed into the 4-entry result queue, then
// loaded into the output stage, which offers its first result beat.
// Throughput: one input byte per cycle while the result queue is not full;
// a byte with two results (data and verdict) needs two output beats.
// Reset (arst_n low, asynchronous): window, count, phase, queue and output
// stage clear; key_chars and key_length return to zero.
// ----------------------------------------------------------------------------
module json_key_string_extractor_top #(
	parameter int unsigned MAX_KEY_LEN = jkse_pkg::MAX_KEY_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	jkse_in_if.sink                       in_ch,
	jkse_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [jkse_pkg::ADDR_W-1:0]   paddr,
	input  logic [jkse_pkg::PDATA_W-1:0]  pwdata,
	output logic [jkse_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic [jkse_pkg::KEY_W-1:0]  key_chars_q;
	logic [jkse_pkg::KLEN_W-1:0] key_length_q;
	logic                        cfg_wr;

	logic                  q_full, q_push, q_pop, q_not_empty;
	jkse_pkg::jkse_entry_t q_entry, q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_chars_q  <= '0;
			key_length_q <= '0;
		end else if (cfg_wr) begin
			case (paddr)
				jkse_pkg::ADDR_KEY_CHARS:  key_chars_q  <= pwdata;
				jkse_pkg::ADDR_KEY_LENGTH: key_length_q <= pwdata[jkse_pkg::KLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			jkse_pkg::ADDR_KEY_CHARS:  prdata = key_chars_q;
			jkse_pkg::ADDR_KEY_LENGTH: prdata = jkse_pkg::PDATA_W'(key_length_q);
			default:                   prdata = '0;
		endcase
	end

	jkse_front #(
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_byte     (in_ch.in_byte),
		.message_end (in_ch.message_end),
		.key_chars   (key_chars_q),
		.key_length  (key_length_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	jkse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	jkse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.value_byte  (out_ch.value_byte),
		.is_final    (out_ch.is_final),
		.found       (out_ch.found)
	);

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JSON key string extractor. A directed run of
// hand-built messages is followed by random messages under several key
// settings; every result beat is checked against a byte-level predictor or a
// pinned expectation, with random gaps on the input and output channels.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 135;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       is_final;
		logic       found;
	} value_res_t;

	typedef enum logic [2:0] {
		SEEK_KEY, SEEK_COLON, SEEK_OPEN, IN_STRING, IN_ESCAPE, VERDICT_DONE
	} scan_phase_t;

	typedef enum logic [1:0] {USE_MODEL, PIN_NONE, PIN_ONE, PIN_TWO} pin_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		pin_t       pin;
		value_res_t r0;
		value_res_t r1;
	} stim_row_t;

	localparam value_res_t NO_RES        = '0;
	localparam value_res_t VERDICT_FOUND = '{8'h00, 1'b1, 1'b1};
	localparam value_res_t VERDICT_MISS  = '{8'h00, 1'b1, 1'b0};

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [jkse_pkg::ADDR_W-1:0] paddr;
	logic [jkse_pkg::PDATA_W-1:0] pwdata, prdata;

	jkse_in_if  in_ch ();
	jkse_out_if out_ch ();

	json_key_string_extractor_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// empty key after reset: the pattern is two adjacent quotes
	stim_row_t directed_rows [26] = '{
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_COLON,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{8'h00,               1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_N,      1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_R,      1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_T,      1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_BSLASH, 1'b0, USE_MODEL, NO_RES, NO_RES},
		'{8'hFF,               1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b0, PIN_ONE,   VERDICT_FOUND, NO_RES},
		'{8'h7A,               1'b1, PIN_NONE,  NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_COLON,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{8'h41,               1'b1, PIN_TWO,   '{8'h41, 1'b0, 1'b0}, VERDICT_MISS},
		'{jkse_pkg::CH_QUOTE,  1'b0, USE_MODEL, NO_RES, NO_RES},
		'{jkse_pkg::CH_QUOTE,  1'b1, PIN_ONE,   VERDICT_MISS, NO_RES}
	};

	// predictor state and register copies
	logic [7:0]  win_bytes [10] = '{default: 8'h00};
	int          win_fill = 0;
	scan_phase_t scan_phase = SEEK_KEY;
	logic [63:0] cfg_key = '0;
	logic [3:0]  cfg_key_len = '0;

	value_res_t  pending_results [$];
	logic [7:0]  msg_bytes [$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int eff_key_len();
		return (cfg_key_len > jkse_pkg::MAX_KEY_LEN_DEF) ?
			jkse_pkg::MAX_KEY_LEN_DEF : int'(cfg_key_len);
	endfunction

	function automatic int extract_step(input logic [7:0] c, input logic last,
		output value_res_t r0, output value_res_t r1);
		value_res_t res [2];
		int         n;
		int         k;
		int         plen;
		logic       verdict;
		logic       hit;
		logic [7:0] want;
		logic [7:0] dec;
		n = 0;
		verdict = 1'b0;
		res[0] = NO_RES;
		res[1] = NO_RES;
		for (k = 9; k > 0; k--) win_bytes[k] = win_bytes[k-1];
		win_bytes[0] = c;
		if (win_fill < 10) win_fill++;
		case (scan_phase)
			SEEK_KEY: begin
				plen = eff_key_len() + 2;
				hit = (win_fill >= plen);
				for (k = 0; k < plen; k++) begin
					if (k == 0 || k == plen - 1) want = jkse_pkg::CH_QUOTE;
					else want = cfg_key[8*(k-1) +: 8];
					if (win_bytes[plen-1-k] != want) hit = 1'b0;
				end
				if (hit) scan_phase = SEEK_COLON;
			end
			SEEK_COLON: if (c == jkse_pkg::CH_COLON) scan_phase = SEEK_OPEN;
			SEEK_OPEN:  if (c == jkse_pkg::CH_QUOTE) scan_phase = IN_STRING;
			IN_STRING: begin
				if (c == jkse_pkg::CH_BSLASH) begin
					scan_phase = IN_ESCAPE;
				end else if (c == jkse_pkg::CH_QUOTE) begin
					res[n] = VERDICT_FOUND;
					n++;
					verdict = 1'b1;
					scan_phase = VERDICT_DONE;
				end else begin
					res[n] = '{c, 1'b0, 1'b0};
					n++;
				end
			end
			IN_ESCAPE: begin
				case (c)
					jkse_pkg::CH_N: dec = jkse_pkg::CH_LF;
					jkse_pkg::CH_R: dec = jkse_pkg::CH_CR;
					jkse_pkg::CH_T: dec = jkse_pkg::CH_TAB;
					default:        dec = c;
				endcase
				res[n] = '{dec, 1'b0, 1'b0};
				n++;
				scan_phase = IN_STRING;
			end
			default: verdict = 1'b1;
		endcase
		if (last) begin
			if (!verdict) begin
				res[n] = VERDICT_MISS;
				n++;
			end
			for (k = 0; k < 10; k++) win_bytes[k] = 8'h00;
			win_fill = 0;
			scan_phase = SEEK_KEY;
		end
		r0 = res[0];
		r1 = res[1];
		return n;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] filler_byte(input logic [7:0] banned);
		logic [7:0] c;
		do begin
			case ($urandom_range(0, 3))
				0:       c = 8'h20;
				1:       c = 8'h2C;
				2:       c = 8'h7B;
				default: c = 8'($urandom);
			endcase
		end while (c == banned);
		return c;
	endfunction

	// mostly well-formed key/value text with random content; some noise,
	// some near-miss keys and some cut short, often at an interesting byte
	function automatic void build_message();
		int         kind;
		int         klen;
		int         i;
		int         cut;
		int         marks [$];
		logic [7:0] c;
		msg_bytes.delete();
		klen = eff_key_len();
		kind = $urandom_range(0, 9);
		if (kind >= 8) begin
			repeat ($urandom_range(1, 16))
				msg_bytes.push_back(($urandom_range(0, 3) == 0) ?
					jkse_pkg::CH_QUOTE : 8'($urandom));
			return;
		end
		repeat ($urandom_range(0, 4)) msg_bytes.push_back(filler_byte(jkse_pkg::CH_QUOTE));
		msg_bytes.push_back(jkse_pkg::CH_QUOTE);
		for (i = 0; i < klen; i++) msg_bytes.push_back(cfg_key[8*i +: 8]);
		if (kind == 7 && klen > 0) begin
			i = msg_bytes.size() - 1 - $urandom_range(0, klen - 1);
			msg_bytes[i] = msg_bytes[i] ^ 8'($urandom_range(1, 255));
		end
		msg_bytes.push_back(jkse_pkg::CH_QUOTE);
		marks.push_back(msg_bytes.size() - 1);
		repeat ($urandom_range(0, 2)) msg_bytes.push_back(filler_byte(jkse_pkg::CH_COLON));
		msg_bytes.push_back(jkse_pkg::CH_COLON);
		marks.push_back(msg_bytes.size() - 1);
		repeat ($urandom_range(0, 2)) msg_bytes.push_back(filler_byte(jkse_pkg::CH_QUOTE));
		msg_bytes.push_back(jkse_pkg::CH_QUOTE);
		marks.push_back(msg_bytes.size() - 1);
		repeat ($urandom_range(0, 10)) begin
			if ($urandom_range(0, 3) == 0) begin
				msg_bytes.push_back(jkse_pkg::CH_BSLASH);
				marks.push_back(msg_bytes.size() - 1);
				case ($urandom_range(0, 5))
					0:       c = jkse_pkg::CH_QUOTE;
					1:       c = jkse_pkg::CH_BSLASH;
					2:       c = jkse_pkg::CH_N;
					3:       c = jkse_pkg::CH_R;
					4:       c = jkse_pkg::CH_T;
					default: c = 8'($urandom);
				endcase
				msg_bytes.push_back(c);
			end else begin
				do c = 8'($urandom);
				while (c == jkse_pkg::CH_QUOTE || c == jkse_pkg::CH_BSLASH);
				msg_bytes.push_back(c);
			end
		end
		if ($urandom_range(0, 9) != 0) msg_bytes.push_back(jkse_pkg::CH_QUOTE);
		repeat ($urandom_range(0, 3)) msg_bytes.push_back(filler_byte(8'h00));
		if ($urandom_range(0, 4) == 0) begin
			if ($urandom_range(0, 1) == 0) cut = marks[$urandom_range(0, marks.size() - 1)];
			else cut = $urandom_range(0, msg_bytes.size() - 1);
			while (msg_bytes.size() > cut + 1) void'(msg_bytes.pop_back());
		end
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic last, input pin_t pin,
		input value_res_t r0, input value_res_t r1);
		int         gap;
		int         n;
		value_res_t p0;
		value_res_t p1;
		gap = pick_gap(no_idle);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.in_byte     <= b;
		in_ch.message_end <= last;
		do @(posedge clk); while (!in_ch.ready);
		n = extract_step(b, last, p0, p1);
		case (pin)
			USE_MODEL: begin
				if (n > 0) pending_results.push_back(p0);
				if (n > 1) pending_results.push_back(p1);
			end
			PIN_ONE: pending_results.push_back(r0);
			PIN_TWO: begin
				pending_results.push_back(r0);
				pending_results.push_back(r1);
			end
			default: ;
		endcase
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [jkse_pkg::ADDR_W-1:0] addr,
		input logic [jkse_pkg::PDATA_W-1:0] data,
		output logic [jkse_pkg::PDATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_register(input logic [jkse_pkg::ADDR_W-1:0] addr,
		input logic [63:0] value);
		logic [jkse_pkg::PDATA_W-1:0] rd;
		logic [jkse_pkg::PDATA_W-1:0] want;
		apb_access(1'b1, addr, value, rd);
		if (addr == jkse_pkg::ADDR_KEY_CHARS) begin
			cfg_key = value;
			want = value;
		end else begin
			cfg_key_len = value[3:0];
			want = {60'd0, value[3:0]};
		end
		apb_access(1'b0, addr, '0, rd);
		if (rd !== want) begin
			$display("%0t: readback of register %0h expected %016h got %016h",
				$time, addr, want, rd);
			error_count++;
		end
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin : sink_loop
			int stall;
			out_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8))
				@(posedge clk);
			stall = pick_gap(1'b0);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		value_res_t exp_r;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat value_byte=%02h is_final=%0b found=%0b",
					$time, out_ch.value_byte, out_ch.is_final, out_ch.found);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_ch.value_byte !== exp_r.value_byte) begin
					$display("%0t: value_byte expected %02h got %02h",
						$time, exp_r.value_byte, out_ch.value_byte);
					error_count++;
				end
				if (out_ch.is_final !== exp_r.is_final) begin
					$display("%0t: is_final expected %0b got %0b",
						$time, exp_r.is_final, out_ch.is_final);
					error_count++;
				end
				if (out_ch.found !== exp_r.found) begin
					$display("%0t: found expected %0b got %0b",
						$time, exp_r.found, out_ch.found);
					error_count++;
				end
			end
		end
	end

	initial begin
		int          p;
		int          i;
		int          j;
		int          sent;
		logic [63:0] kc;
		logic [3:0]  kl;
		arst_n = 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.in_byte     <= 8'h00;
		in_ch.message_end <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].b, directed_rows[i].last, directed_rows[i].pin,
				directed_rows[i].r0, directed_rows[i].r1);

		for (p = 0; p < 10; p++) begin
			if (p > 0) begin
				settle();
				kc = {$urandom, $urandom};
				case (p)
					1: begin kc = '1; kl = 4'hF; end
					2: kl = 4'd8;
					3: kl = 4'd1;
					4: begin kc = '0; kl = 4'd0; end
					5: kl = 4'($urandom_range(9, 14));
					default: begin
						for (j = 0; j < 8; j++) kc[8*j +: 8] = 8'($urandom_range(8'h61, 8'h7A));
						kl = 4'($urandom_range(1, 7));
					end
				endcase
				write_register(jkse_pkg::ADDR_KEY_CHARS, kc);
				write_register(jkse_pkg::ADDR_KEY_LENGTH, {60'd0, kl});
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_message();
				no_idle = ($urandom_range(0, 7) == 0);
				for (i = 0; i < msg_bytes.size(); i++)
					send_beat(msg_bytes[i], i == msg_bytes.size() - 1, USE_MODEL, NO_RES, NO_RES);
				sent += msg_bytes.size();
				if ($urandom_range(0, 24) == 0) settle();
			end
		end

		settle();
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
